@@ hw/rtl/dwlf_pkg.sv @@
// Package for the dual white LED fader: constants, codes, state enum,
// divider request/response structs and the gamma correction table.
// No dependencies.
package dwlf_pkg;

    localparam int FADE_PERIOD_TICKS = 10;
    localparam int GAMMA_TENTHS      = 22;
    localparam int PULSE_STEPS       = 20;
    localparam int PULSE_STEP_TICKS  = 8;
    localparam int PULSE_PAUSE_TICKS = 80;

    // Shared divider: quotient always fits 8 bits, so numerator < 2^8 * divisor
    localparam int DIV_DEN_W = 16;
    localparam int DIV_QUO_W = 8;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PULSE = 1'b1;

    typedef enum logic [2:0] {
        CFG_LAMP_ON    = 3'd0,
        CFG_COLOR_TEMP = 3'd1,
        CFG_MAX_DUTY   = 3'd2,
        CFG_FADE_ANGLE = 3'd3,
        CFG_TEMP_MIN   = 3'd4,
        CFG_TEMP_MAX   = 3'd5,
        CFG_FADE_STEP  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_FADE_DOWN  = 2'd0,
        PH_PAUSE_LOW  = 2'd1,
        PH_FADE_UP    = 2'd2,
        PH_PAUSE_HIGH = 2'd3
    } t_pulse_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERC,
        ST_PERC_WAIT,
        ST_SPLIT,
        ST_WARM_WAIT,
        ST_COOL_WAIT,
        ST_SLEW,
        ST_OUT,
        ST_PW_WAIT,
        ST_PC_WAIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_QUO_W-1:0] quot;
    } t_div_rsp;

    typedef logic [7:0] t_gamma_rom [256];

    // round(255 * (p/255)^(GAMMA_TENTHS/10)), evaluated at elaboration
    function automatic t_gamma_rom gamma_build();
        t_gamma_rom rom;
        real        x;
        real        y;
        for (int p = 0; p < 256; p++) begin
            x = real'(p) / 255.0;
            y = 255.0 * (x ** (real'(GAMMA_TENTHS) / 10.0)) + 0.5;
            rom[p] = 8'($rtoi(y));
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = gamma_build();

endpackage

@@ hw/rtl/dwlf_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on dwlf_pkg (widths, request/response structs).
module dwlf_div import dwlf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_QUO_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign shifted = {r_rem, r_quo[DIV_QUO_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DIV_CNT_W'(DIV_QUO_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end
        end
    end

    // Low numerator bits shift out of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[DIV_NUM_W-1:DIV_QUO_W];
            r_quo <= i_req.num[DIV_QUO_W-1:0];
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_QUO_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ hw/rtl/dual_white_led_fader_with_pulse_unit.sv @@
// Dual white LED fader with pulse feedback: sequencer around one shared divider.
// Work per item: an item without division does not use the divider, an item
// while a pulse runs takes two divisions, and a tick that updates the fader up to three;
// each division holds the shared divider, which makes one quotient bit per cycle.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset clears state and loads register defaults.
module dual_white_led_fader_with_pulse_unit import dwlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // shaft_angle[15:0], pulse_count[23:16]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // warm_duty[7:0], cool_duty[15:8]
    output logic        m_axis_tuser,  // pulse_busy
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic        r_lamp_on;
    logic [15:0] r_color_temp;
    logic [7:0]  r_max_duty;
    logic [14:0] r_fade_angle;
    logic [15:0] r_temp_min;
    logic [15:0] r_temp_max;
    logic [7:0]  r_fade_step;

    t_state       r_state, n_state;
    logic [7:0]   r_warm_level, n_warm_level;
    logic [7:0]   r_cool_level, n_cool_level;
    logic [7:0]   r_fade_cnt, n_fade_cnt;
    logic         r_pulse_active, n_pulse_active;
    logic [7:0]   r_saved_warm, n_saved_warm;
    logic [7:0]   r_saved_cool, n_saved_cool;
    logic [7:0]   r_cycles_left, n_cycles_left;
    t_pulse_phase r_pulse_phase, n_pulse_phase;
    logic [4:0]   r_pulse_level, n_pulse_level;
    logic [6:0]   r_phase_timer, n_phase_timer;

    logic signed [15:0] r_angle, n_angle;
    logic [7:0]   r_perc, n_perc;
    logic [7:0]   r_peak, n_peak;
    logic [7:0]   r_tw, n_tw;
    logic [7:0]   r_tc, n_tc;
    logic [7:0]   r_res_warm, n_res_warm;
    logic [7:0]   r_res_cool, n_res_cool;
    logic         r_res_busy, n_res_busy;
    logic [7:0]   r_out_warm, n_out_warm;
    logic [7:0]   r_out_cool, n_out_cool;
    logic         r_out_busy, n_out_busy;
    logic         r_out_valid, n_out_valid;

    t_div_req     div_req;
    t_div_rsp     div_rsp;

    logic         in_accept;
    logic         out_free;
    logic [15:0]  ct_clamp;
    logic [15:0]  span;
    logic [15:0]  warm_diff;
    logic [15:0]  cool_diff;
    logic         angle_full;
    logic [8:0]   fade_cnt_inc;
    logic [6:0]   timer_inc;
    logic [7:0]   gamma_val;
    logic [15:0]  mul_a;
    logic [7:0]   mul_b;
    logic [23:0]  mul_p;

    dwlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    function automatic logic [7:0] slew_level(input logic [7:0] cur, input logic [7:0] tgt,
                                              input logic [7:0] step);
        logic [8:0] up;
        logic [7:0] dn;
        logic [7:0] res;
        up  = {1'b0, cur} + {1'b0, step};
        dn  = cur - step;
        res = cur;
        if (cur < tgt) begin
            res = (up <= {1'b0, tgt}) ? up[7:0] : tgt;
        end else if (cur > tgt) begin
            res = (cur > step && dn >= tgt) ? dn : tgt;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_on    <= 1'b1;
            r_color_temp <= 16'd250;
            r_max_duty   <= 8'd255;
            r_fade_angle <= 15'd4096;
            r_temp_min   <= 16'd153;
            r_temp_max   <= 16'd500;
            r_fade_step  <= 8'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LAMP_ON:    r_lamp_on    <= i_cfg_data[0];
                CFG_COLOR_TEMP: r_color_temp <= i_cfg_data;
                CFG_MAX_DUTY:   r_max_duty   <= i_cfg_data[7:0];
                CFG_FADE_ANGLE: r_fade_angle <= i_cfg_data[14:0];
                CFG_TEMP_MIN:   r_temp_min   <= i_cfg_data;
                CFG_TEMP_MAX:   r_temp_max   <= i_cfg_data;
                CFG_FADE_STEP:  r_fade_step  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign ct_clamp  = (r_color_temp < r_temp_min) ? r_temp_min :
                       (r_color_temp > r_temp_max) ? r_temp_max : r_color_temp;
    assign span      = r_temp_max - r_temp_min;
    assign warm_diff = ct_clamp - r_temp_min;
    assign cool_diff = r_temp_max - ct_clamp;

    // Any positive angle counts as full ramp when fade_angle is zero
    assign angle_full   = (r_fade_angle == '0) || (r_angle[14:0] >= r_fade_angle);
    assign fade_cnt_inc = {1'b0, r_fade_cnt} + 9'd1;
    assign timer_inc    = r_phase_timer + 7'd1;
    assign gamma_val    = GAMMA_ROM[r_perc];
    assign mul_p        = mul_a * mul_b;

    always_comb begin
        n_state        = r_state;
        n_warm_level   = r_warm_level;
        n_cool_level   = r_cool_level;
        n_fade_cnt     = r_fade_cnt;
        n_pulse_active = r_pulse_active;
        n_saved_warm   = r_saved_warm;
        n_saved_cool   = r_saved_cool;
        n_cycles_left  = r_cycles_left;
        n_pulse_phase  = r_pulse_phase;
        n_pulse_level  = r_pulse_level;
        n_phase_timer  = r_phase_timer;
        n_angle        = r_angle;
        n_perc         = r_perc;
        n_peak         = r_peak;
        n_tw           = r_tw;
        n_tc           = r_tc;
        n_res_warm     = r_res_warm;
        n_res_cool     = r_res_cool;
        n_res_busy     = r_res_busy;
        n_out_warm     = r_out_warm;
        n_out_cool     = r_out_cool;
        n_out_busy     = r_out_busy;
        n_out_valid    = r_out_valid && !m_axis_tready;
        mul_a          = '0;
        mul_b          = '0;
        div_req.start  = 1'b0;
        div_req.num    = DIV_NUM_W'(mul_p);
        div_req.den    = DIV_DEN_W'(PULSE_STEPS);
        s_axis_tready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_OUT;
                    if (s_axis_tuser == CMD_PULSE) begin
                        if (s_axis_tdata[23:16] != 8'd0 && !r_pulse_active) begin
                            n_saved_warm   = r_warm_level;
                            n_saved_cool   = r_cool_level;
                            n_cycles_left  = s_axis_tdata[23:16];
                            n_pulse_active = 1'b1;
                            n_pulse_phase  = PH_FADE_DOWN;
                            n_pulse_level  = 5'(PULSE_STEPS);
                            n_phase_timer  = '0;
                        end
                    end else begin
                        n_angle    = s_axis_tdata[15:0];
                        n_fade_cnt = (fade_cnt_inc >= 9'(FADE_PERIOD_TICKS)) ?
                                     8'd0 : fade_cnt_inc[7:0];
                        if (r_pulse_active) begin
                            n_phase_timer = timer_inc;
                            case (r_pulse_phase)
                                PH_FADE_DOWN, PH_FADE_UP: begin
                                    if (timer_inc >= 7'(PULSE_STEP_TICKS)) begin
                                        n_phase_timer = '0;
                                        if (r_pulse_phase == PH_FADE_DOWN) begin
                                            if (r_pulse_level == '0) begin
                                                n_pulse_phase = PH_PAUSE_LOW;
                                            end else begin
                                                n_pulse_level = r_pulse_level - 5'd1;
                                            end
                                        end else begin
                                            if (r_pulse_level >= 5'(PULSE_STEPS)) begin
                                                n_pulse_phase = PH_PAUSE_HIGH;
                                            end else begin
                                                n_pulse_level = r_pulse_level + 5'd1;
                                            end
                                        end
                                    end
                                end
                                PH_PAUSE_LOW: begin
                                    if (timer_inc >= 7'(PULSE_PAUSE_TICKS)) begin
                                        n_phase_timer = '0;
                                        n_pulse_phase = PH_FADE_UP;
                                        n_pulse_level = '0;
                                    end
                                end
                                PH_PAUSE_HIGH: begin
                                    if (timer_inc >= 7'(PULSE_PAUSE_TICKS)) begin
                                        n_phase_timer = '0;
                                        n_cycles_left = r_cycles_left - 8'd1;
                                        n_pulse_phase = PH_FADE_DOWN;
                                        n_pulse_level = 5'(PULSE_STEPS);
                                        // last cycle done: restore the saved duties
                                        if (r_cycles_left == 8'd1) begin
                                            n_warm_level   = r_saved_warm;
                                            n_cool_level   = r_saved_cool;
                                            n_pulse_active = 1'b0;
                                            n_pulse_level  = '0;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end else if (r_fade_cnt == 8'd0) begin
                            n_state = ST_PERC;
                        end
                    end
                end
            end

            ST_PERC: begin
                if (!r_lamp_on) begin
                    n_tw    = '0;
                    n_tc    = '0;
                    n_state = ST_SLEW;
                end else if (r_angle[15] || r_angle == '0) begin
                    n_perc  = '0;
                    n_state = ST_SPLIT;
                end else if (angle_full) begin
                    n_perc  = r_max_duty;
                    n_state = ST_SPLIT;
                end else begin
                    // (2*angle*max_duty + fade_angle) / (2*fade_angle) rounds to nearest
                    mul_a         = {1'b0, r_angle[14:0]};
                    mul_b         = r_max_duty;
                    div_req.start = 1'b1;
                    div_req.num   = {mul_p[DIV_NUM_W-2:0], 1'b0} + DIV_NUM_W'(r_fade_angle);
                    div_req.den   = {r_fade_angle, 1'b0};
                    n_state       = ST_PERC_WAIT;
                end
            end

            ST_PERC_WAIT: begin
                if (div_rsp.done) begin
                    n_perc  = div_rsp.quot;
                    n_state = ST_SPLIT;
                end
            end

            ST_SPLIT: begin
                n_peak = gamma_val;
                if (r_temp_max <= r_temp_min) begin
                    n_tw    = gamma_val;
                    n_tc    = '0;
                    n_state = ST_SLEW;
                end else begin
                    mul_a         = warm_diff;
                    mul_b         = gamma_val;
                    div_req.start = 1'b1;
                    div_req.den   = span;
                    n_state       = ST_WARM_WAIT;
                end
            end

            ST_WARM_WAIT: begin
                if (div_rsp.done) begin
                    n_tw          = div_rsp.quot;
                    mul_a         = cool_diff;
                    mul_b         = r_peak;
                    div_req.start = 1'b1;
                    div_req.den   = span;
                    n_state       = ST_COOL_WAIT;
                end
            end

            ST_COOL_WAIT: begin
                if (div_rsp.done) begin
                    n_tc    = div_rsp.quot;
                    n_state = ST_SLEW;
                end
            end

            ST_SLEW: begin
                n_warm_level = slew_level(r_warm_level, r_tw, r_fade_step);
                n_cool_level = slew_level(r_cool_level, r_tc, r_fade_step);
                n_state      = ST_OUT;
            end

            ST_OUT: begin
                if (r_pulse_active) begin
                    mul_a         = {8'd0, r_saved_warm};
                    mul_b         = {3'd0, r_pulse_level};
                    div_req.start = 1'b1;
                    n_state       = ST_PW_WAIT;
                end else begin
                    n_res_warm = r_warm_level;
                    n_res_cool = r_cool_level;
                    n_res_busy = 1'b0;
                    n_state    = ST_LOAD;
                end
            end

            ST_PW_WAIT: begin
                if (div_rsp.done) begin
                    n_res_warm    = div_rsp.quot;
                    mul_a         = {8'd0, r_saved_cool};
                    mul_b         = {3'd0, r_pulse_level};
                    div_req.start = 1'b1;
                    n_state       = ST_PC_WAIT;
                end
            end

            ST_PC_WAIT: begin
                if (div_rsp.done) begin
                    n_res_cool = div_rsp.quot;
                    n_res_busy = 1'b1;
                    n_state    = ST_LOAD;
                end
            end

            ST_LOAD: begin
                // hold until the output register is free or being drained
                if (out_free) begin
                    n_out_warm  = r_res_warm;
                    n_out_cool  = r_res_cool;
                    n_out_busy  = r_res_busy;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (!in_accept && r_state == ST_IDLE) begin
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_warm_level   <= '0;
            r_cool_level   <= '0;
            r_fade_cnt     <= '0;
            r_pulse_active <= 1'b0;
            r_saved_warm   <= '0;
            r_saved_cool   <= '0;
            r_cycles_left  <= '0;
            r_pulse_phase  <= PH_FADE_DOWN;
            r_pulse_level  <= '0;
            r_phase_timer  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_warm_level   <= n_warm_level;
            r_cool_level   <= n_cool_level;
            r_fade_cnt     <= n_fade_cnt;
            r_pulse_active <= n_pulse_active;
            r_saved_warm   <= n_saved_warm;
            r_saved_cool   <= n_saved_cool;
            r_cycles_left  <= n_cycles_left;
            r_pulse_phase  <= n_pulse_phase;
            r_pulse_level  <= n_pulse_level;
            r_phase_timer  <= n_phase_timer;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle    <= n_angle;
        r_perc     <= n_perc;
        r_peak     <= n_peak;
        r_tw       <= n_tw;
        r_tc       <= n_tc;
        r_res_warm <= n_res_warm;
        r_res_cool <= n_res_cool;
        r_res_busy <= n_res_busy;
        r_out_warm <= n_out_warm;
        r_out_cool <= n_out_cool;
        r_out_busy <= n_out_busy;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cool, r_out_warm};
    assign m_axis_tuser  = r_out_busy;

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("item accepted while previous item still in work");

    a_idle_pulse_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pulse_active |-> r_pulse_level == '0)
        else $error("pulse level left nonzero with no pulse running");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_PERC_WAIT || r_state == ST_WARM_WAIT ||
                          r_state == ST_COOL_WAIT || r_state == ST_PW_WAIT ||
                          r_state == ST_PC_WAIT))
        else $error("divider finished while sequencer was not waiting");

endmodule
